// ===== sv/qlbs_pkg.sv =====
// Shared types and constants of the Q-learning backend selector.
`timescale 1ns / 1ps
package qlbs_pkg;

	localparam int BACKEND_SLOTS_DEF = 8;
	localparam int STATE_SLOTS_DEF   = 16;

	localparam int RATE_W = 17;
	localparam int Q_W    = 16;
	localparam int CNT_W  = 11;
	localparam logic [RATE_W-1:0] ONE_Q16 = 17'h10000;

	// register map, byte address 4*index
	typedef enum logic [2:0] {
		REG_BACKENDS = 3'd0,
		REG_STATES   = 3'd1,
		REG_LEARN    = 3'd2,
		REG_DISCOUNT = 3'd3,
		REG_DECAY    = 3'd4,
		REG_MIN_EXP  = 3'd5
	} reg_idx_t;

	// raw configuration as written
	typedef struct packed {
		logic [3:0]        backends;
		logic [4:0]        states;
		logic [RATE_W-1:0] learn;
		logic [RATE_W-1:0] discount;
		logic [RATE_W-1:0] decay;
		logic [RATE_W-1:0] min_exp;
	} cfg_t;

endpackage

// ===== sv/q_learning_backend_selector.sv =====
// Top level of the Q-learning backend selector.
// The block handles one item at a time and clears its Q table after reset,
// during which no item is taken. A select item that explores runs a 16-step
// modulo of random_pick; an exploiting select makes one table read per
// backend from the single-read-port table memory; a feedback item scans the
// next state, then runs the multiply chain in split partial products and the
// epsilon decay. The result register lets a new item be accepted while a
// result still waits.
`timescale 1ns / 1ps
module q_learning_backend_selector
	import qlbs_pkg::*;
#(
	parameter int BACKEND_SLOTS = BACKEND_SLOTS_DEF,
	parameter int STATE_SLOTS   = STATE_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [3:0]         current_load,
	input  logic [3:0]         next_load,
	input  logic [2:0]         served_backend,
	input  logic signed [15:0] reward_value,
	input  logic [15:0]        random_draw,
	input  logic [15:0]        random_pick,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         chosen_backend,
	output logic               explored,
	output logic signed [15:0] updated_value,
	output logic [16:0]        exploration_rate
);
	cfg_t cfg;

	qlbs_apb u_apb (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	qlbs_core #(.BACKEND_SLOTS(BACKEND_SLOTS), .STATE_SLOTS(STATE_SLOTS)) u_core (
		.clk, .arst_n, .cfg, .in_valid, .in_stall, .mode, .current_load,
		.next_load, .served_backend, .reward_value, .random_draw, .random_pick,
		.out_valid, .out_stall, .chosen_backend, .explored, .updated_value,
		.exploration_rate
	);
endmodule

// ===== sv/qlbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module qlbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/qlbs_apb.sv =====
// APB configuration registers of the backend selector.
`timescale 1ns / 1ps
module qlbs_apb
	import qlbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	cfg_t              cfg_q;
	logic              wr;
	logic [RATE_W-1:0] wr_rate;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);
	// rates saturate at 1.0 on write
	assign wr_rate = (pwdata[RATE_W-1:0] > ONE_Q16) ? ONE_Q16 : pwdata[RATE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.backends <= 4'd8;
			cfg_q.states   <= 5'd16;
			cfg_q.learn    <= 17'd19661;
			cfg_q.discount <= 17'd32768;
			cfg_q.decay    <= 17'd62259;
			cfg_q.min_exp  <= 17'd3277;
		end else if (wr) begin
			case (idx)
				REG_BACKENDS: cfg_q.backends <= pwdata[3:0];
				REG_STATES:   cfg_q.states   <= pwdata[4:0];
				REG_LEARN:    cfg_q.learn    <= wr_rate;
				REG_DISCOUNT: cfg_q.discount <= wr_rate;
				REG_DECAY:    cfg_q.decay    <= wr_rate;
				REG_MIN_EXP:  cfg_q.min_exp  <= wr_rate;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_BACKENDS: prdata = 32'(cfg_q.backends);
			REG_STATES:   prdata = 32'(cfg_q.states);
			REG_LEARN:    prdata = 32'(cfg_q.learn);
			REG_DISCOUNT: prdata = 32'(cfg_q.discount);
			REG_DECAY:    prdata = 32'(cfg_q.decay);
			REG_MIN_EXP:  prdata = 32'(cfg_q.min_exp);
			default:      prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;
endmodule

// ===== sv/qlbs_core.sv =====
// Sequencer, arithmetic and Q table of the backend selector.
`timescale 1ns / 1ps
module qlbs_core
	import qlbs_pkg::*;
#(
	parameter int BACKEND_SLOTS = BACKEND_SLOTS_DEF,
	parameter int STATE_SLOTS   = STATE_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [3:0]         current_load,
	input  logic [3:0]         next_load,
	input  logic [2:0]         served_backend,
	input  logic signed [15:0] reward_value,
	input  logic [15:0]        random_draw,
	input  logic [15:0]        random_pick,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         chosen_backend,
	output logic               explored,
	output logic signed [15:0] updated_value,
	output logic [16:0]        exploration_rate
);
	localparam int BW    = (BACKEND_SLOTS > 1) ? $clog2(BACKEND_SLOTS) : 1;
	localparam int SW    = (STATE_SLOTS > 1) ? $clog2(STATE_SLOTS) : 1;
	localparam int AW    = SW + BW;
	localparam int DEPTH = 2 ** AW;
	localparam int BC_W  = $clog2(BACKEND_SLOTS + 1);
	localparam int TD_W  = 35;
	localparam int PR_W  = 53;

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_SCAN  = 13'b0000000000100,
		S_MOD   = 13'b0000000001000,
		S_RDQ   = 13'b0000000010000,
		S_MULG  = 13'b0000000100000,
		S_TD    = 13'b0000001000000,
		S_MLO   = 13'b0000010000000,
		S_MHI   = 13'b0000100000000,
		S_SUM   = 13'b0001000000000,
		S_UPD   = 13'b0010000000000,
		S_EPS   = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t                   state_q;
	logic [AW-1:0]            clr_q;
	logic                     mode_q, expl_q;
	logic [SW-1:0]            cur_q, scan_s_q;
	logic [BW-1:0]            bk_q, best_q, pidx_q;
	logic signed [Q_W-1:0]    reward_q, maxq_q, oldq_q, upd_q;
	logic [15:0]              pick_q;
	logic [BC_W-1:0]          issue_q;
	logic                     pend_q;
	logic [BC_W:0]            rem_q;
	logic [3:0]               bit_q;
	logic signed [33:0]       gm_q;
	logic signed [TD_W-1:0]   td_q;
	logic [34:0]              plo_q;
	logic signed [34:0]       phi_q;
	logic signed [20:0]       delta_q;
	logic [33:0]              emul_q;
	logic [RATE_W-1:0]        eps_q;

	logic                     out_valid_q, expl_out_q;
	logic [2:0]               chosen_q;
	logic signed [Q_W-1:0]    updv_q;
	logic [RATE_W-1:0]        rate_q;

	// effective counts and clamped indexes
	logic [CNT_W-1:0] nb_raw, ns_raw, nb_w, ns_w, cur_w, nxt_w, bk_w;
	logic [BC_W-1:0]  nb;

	assign nb_raw = CNT_W'(cfg.backends);
	assign ns_raw = CNT_W'(cfg.states);
	assign nb_w = (nb_raw == '0) ? CNT_W'(1) :
		(nb_raw > CNT_W'(BACKEND_SLOTS)) ? CNT_W'(BACKEND_SLOTS) : nb_raw;
	assign ns_w = (ns_raw == '0) ? CNT_W'(1) :
		(ns_raw > CNT_W'(STATE_SLOTS)) ? CNT_W'(STATE_SLOTS) : ns_raw;
	assign nb = nb_w[BC_W-1:0];
	assign cur_w = (CNT_W'(current_load) >= ns_w) ? ns_w - CNT_W'(1) : CNT_W'(current_load);
	assign nxt_w = (CNT_W'(next_load) >= ns_w) ? ns_w - CNT_W'(1) : CNT_W'(next_load);
	assign bk_w  = (CNT_W'(served_backend) >= nb_w) ? nb_w - CNT_W'(1)
		: CNT_W'(served_backend);

	// saturated new entry
	logic signed [21:0]    nq_w;
	logic signed [Q_W-1:0] nq_sat;
	assign nq_w   = 22'(oldq_q) + 22'(delta_q);
	assign nq_sat = (nq_w > 22'sd32767) ? 16'sh7FFF :
		(nq_w < -22'sd32768) ? 16'sh8000 : nq_w[Q_W-1:0];

	// table memory
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic signed [Q_W-1:0] ram_wdata, ram_rdata;

	qlbs_ram #(.WIDTH(Q_W), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_UPD);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : {cur_q, bk_q};
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : nq_sat;
	assign ram_re    = ((state_q == S_SCAN) && (issue_q != nb)) || (state_q == S_RDQ);
	assign ram_raddr = (state_q == S_RDQ) ? {cur_q, bk_q} : {scan_s_q, issue_q[BW-1:0]};

	// modulo step: one quotient bit per cycle
	logic [BC_W:0] r_sh, r_next;
	assign r_sh   = {rem_q[BC_W-1:0], pick_q[bit_q]};
	assign r_next = (r_sh >= {1'b0, nb}) ? r_sh - {1'b0, nb} : r_sh;

	// rounded product, floor of (prod + 2^31) / 2^32
	logic signed [PR_W-1:0] prod_sum;
	assign prod_sum = (PR_W'(phi_q) <<< 18) + $signed(PR_W'(plo_q))
		+ $signed(PR_W'(64'h80000000));

	// epsilon decay and floor
	logic [RATE_W-1:0] eps_dec, eps_next;
	logic [33:0]       emul_r;
	assign emul_r   = emul_q + 34'd32768;
	assign eps_dec  = (eps_q > cfg.min_exp) ? emul_r[32:16] : eps_q;
	assign eps_next = (eps_dec < cfg.min_exp) ? cfg.min_exp : eps_dec;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			eps_q   <= ONE_Q16;
			pend_q  <= 1'b0;
			issue_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					issue_q <= '0;
					pend_q  <= 1'b0;
					if (in_valid) begin
						if (mode) begin
							scan_s_q <= nxt_w[SW-1:0];
							state_q  <= S_SCAN;
						end else if ({1'b0, random_draw} < eps_q) begin
							state_q <= S_MOD;
						end else begin
							scan_s_q <= cur_w[SW-1:0];
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue_q != nb) issue_q <= issue_q + BC_W'(1);
					pend_q <= (issue_q != nb);
					if (issue_q == nb && !pend_q) state_q <= mode_q ? S_RDQ : S_DONE;
				end
				S_MOD: begin
					if (bit_q == 4'd0) state_q <= S_DONE;
				end
				S_RDQ:  state_q <= S_MULG;
				S_MULG: state_q <= S_TD;
				S_TD:   state_q <= S_MLO;
				S_MLO:  state_q <= S_MHI;
				S_MHI:  state_q <= S_SUM;
				S_SUM:  state_q <= S_UPD;
				S_UPD:  state_q <= S_EPS;
				S_EPS: begin
					eps_q   <= eps_next;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q   <= mode;
				cur_q    <= cur_w[SW-1:0];
				bk_q     <= bk_w[BW-1:0];
				reward_q <= reward_value;
				pick_q   <= random_pick;
				rem_q    <= '0;
				bit_q    <= 4'd15;
				expl_q   <= !mode && ({1'b0, random_draw} < eps_q);
			end
			S_SCAN: begin
				pidx_q <= issue_q[BW-1:0];
				if (pend_q && (pidx_q == '0 || ram_rdata > maxq_q)) begin
					maxq_q <= ram_rdata;
					best_q <= pidx_q;
				end
			end
			S_MOD: begin
				rem_q <= r_next;
				bit_q <= bit_q - 4'd1;
			end
			S_MULG: begin
				oldq_q <= ram_rdata;
				gm_q   <= $signed({1'b0, cfg.discount}) * maxq_q;
			end
			S_TD: td_q <= (TD_W'(reward_q) <<< 16) + TD_W'(gm_q) - (TD_W'(oldq_q) <<< 16);
			S_MLO: plo_q <= cfg.learn * td_q[17:0];
			S_MHI: phi_q <= $signed({1'b0, cfg.learn}) * $signed(td_q[TD_W-1:18]);
			S_SUM: delta_q <= prod_sum[PR_W-1:32];
			S_UPD: begin
				upd_q  <= nq_sat;
				emul_q <= eps_q * cfg.decay;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			chosen_q   <= mode_q ? 3'd0 : (expl_q ? 3'(rem_q) : 3'(best_q));
			expl_out_q <= expl_q;
			updv_q     <= mode_q ? upd_q : '0;
			rate_q     <= eps_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign chosen_backend   = chosen_q;
	assign explored         = expl_out_q;
	assign updated_value    = updv_q;
	assign exploration_rate = rate_q;
endmodule

// ===== sv/qlbs_checker.sv =====
// Port-level checks for the backend selector, bound to the top level.
`timescale 1ns / 1ps
module qlbs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         chosen_backend,
	input logic               explored,
	input logic signed [15:0] updated_value,
	input logic [16:0]        exploration_rate
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(updated_value)
		&& $stable(chosen_backend) && $stable(exploration_rate))
		else $error("stalled result changed");

	// exploration only on select transfers
	a_expl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && explored |-> updated_value == 16'sd0)
		else $error("explored result carries a value");

	// rate never above one
	a_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> exploration_rate <= 17'h10000)
		else $error("exploration rate above one");

	// select and feedback fields are exclusive
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chosen_backend == 3'd0 || updated_value == 16'sd0)
		else $error("both backend and value set");
endmodule

bind q_learning_backend_selector qlbs_checker u_qlbs_checker (.*);

// ===== dv/q_learning_backend_selector_checker.sv =====
// Checker for the Q-learning backend selector: predicts each result and compares.
`timescale 1ns / 1ps
module q_learning_backend_selector_checker
	import qlbs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               mode,
	input  logic [3:0]         current_load,
	input  logic [3:0]         next_load,
	input  logic [2:0]         served_backend,
	input  logic signed [15:0] reward_value,
	input  logic [15:0]        random_draw,
	input  logic [15:0]        random_pick,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [2:0]         chosen_backend,
	input  logic               explored,
	input  logic signed [15:0] updated_value,
	input  logic [16:0]        exploration_rate,
	output int                 fail_count,
	output int                 pending_count
);

	typedef struct packed {
		logic [2:0]  backend;
		logic        expl;
		logic [15:0] qval;
		logic [16:0] eps;
	} sel_result_t;

	sel_result_t pending_results[$];
	logic signed [15:0] q_shadow [0:127];
	logic [16:0] eps_shadow;
	logic [3:0]  cfg_backends;
	logic [4:0]  cfg_states;
	logic [16:0] cfg_learn, cfg_disc, cfg_decay, cfg_min;

	assign pending_count = pending_results.size();

	function automatic int backends_used();
		if (cfg_backends == 0) return 1;
		if (cfg_backends > 8) return 8;
		return cfg_backends;
	endfunction

	function automatic int clamp_load(logic [3:0] s);
		int n;
		n = (cfg_states == 0) ? 1 : (cfg_states > 16) ? 16 : cfg_states;
		return (s >= n) ? n - 1 : s;
	endfunction

	function automatic logic [16:0] sat_rate(logic [31:0] v);
		return (v[16:0] > 17'h10000) ? 17'h10000 : v[16:0];
	endfunction

	// argmax over the backends in use, lowest index wins ties
	function automatic int best_of(int s, output longint best_q);
		int b;
		b = 0;
		best_q = q_shadow[s*8];
		for (int a = 1; a < backends_used(); a++)
			if (q_shadow[s*8+a] > best_q) begin
				best_q = q_shadow[s*8+a];
				b = a;
			end
		return b;
	endfunction

	// update the shadow state for one input transfer and queue its result
	task automatic predict_transfer();
		sel_result_t r;
		int cur, nxt, bk, idx;
		longint maxq, oldq, td, prod, delta, nq, bq;
		longint sum;
		r = '0;
		cur = clamp_load(current_load);
		if (!mode) begin
			if (random_draw < eps_shadow) begin
				r.backend = 3'(random_pick % backends_used());
				r.expl = 1'b1;
			end else begin
				r.backend = 3'(best_of(cur, bq));
			end
		end else begin
			nxt = clamp_load(next_load);
			bk = served_backend;
			if (bk >= backends_used()) bk = backends_used() - 1;
			idx = cur*8 + bk;
			oldq = q_shadow[idx];
			void'(best_of(nxt, maxq));
			td = longint'(reward_value) * 65536 + longint'(cfg_disc) * maxq - oldq * 65536;
			prod = longint'(cfg_learn) * td;
			sum = prod + (64'sd1 <<< 31);
			delta = sum >>> 32;
			nq = oldq + delta;
			if (nq > 32767) nq = 32767;
			if (nq < -32768) nq = -32768;
			q_shadow[idx] = nq[15:0];
			r.qval = nq[15:0];
			if (eps_shadow > cfg_min)
				eps_shadow = 17'((longint'(eps_shadow) * cfg_decay + 32768) >> 16);
			if (eps_shadow < cfg_min) eps_shadow = cfg_min;
		end
		r.eps = eps_shadow;
		pending_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		sel_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < 128; i++) q_shadow[i] = '0;
			eps_shadow = 17'h10000;
			cfg_backends = 4'd8;
			cfg_states = 5'd16;
			cfg_learn = 17'd19661;
			cfg_disc = 17'd32768;
			cfg_decay = 17'd62259;
			cfg_min = 17'd3277;
			pending_results.delete();
			fail_count = 0;
		end else begin
			// configuration write
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_BACKENDS: cfg_backends = pwdata[3:0];
					REG_STATES:   cfg_states = pwdata[4:0];
					REG_LEARN:    cfg_learn = sat_rate(pwdata);
					REG_DISCOUNT: cfg_disc = sat_rate(pwdata);
					REG_DECAY:    cfg_decay = sat_rate(pwdata);
					REG_MIN_EXP:  cfg_min = sat_rate(pwdata);
					default: ;
				endcase
			end
			// result transfer, checked before the new input is predicted
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result backend=%0d", $time, chosen_backend);
					fail_count++;
				end else begin
					e = pending_results.pop_front();
					if (e.backend !== chosen_backend || e.expl !== explored ||
							e.qval !== updated_value || e.eps !== exploration_rate) begin
						$display("%0t: mismatch expected b=%0d x=%0d q=%0d e=%0d", $time,
							e.backend, e.expl, $signed(e.qval), e.eps);
						$display("%0t:          actual   b=%0d x=%0d q=%0d e=%0d", $time,
							chosen_backend, explored, updated_value, exploration_rate);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) predict_transfer();
		end
	end

endmodule

// ===== dv/q_learning_backend_selector_tb.sv =====
// Testbench top for the Q-learning backend selector: stimulus and verdict.
`timescale 1ns / 1ps
module q_learning_backend_selector_tb;
	import qlbs_pkg::*;

	logic clk = 1'b0, arst_n = 1'b0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic mode = 0;
	logic [3:0] current_load = 0, next_load = 0;
	logic [2:0] served_backend = 0;
	logic signed [15:0] reward_value = 0;
	logic [15:0] random_draw = 0, random_pick = 0;
	logic out_valid, out_stall = 0;
	logic [2:0] chosen_backend;
	logic explored;
	logic signed [15:0] updated_value;
	logic [16:0] exploration_rate;
	int fail_count, pending_count;
	int cycles = 0, sent = 0, selects = 0, feedbacks = 0;
	bit stall_long;

	localparam int LIMIT = 400000;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	q_learning_backend_selector uut (.*);
	q_learning_backend_selector_checker chk (.*);

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("q_learning_backend_selector regression: fail");
			$finish;
		end
	end

	// receiver stalls: mostly short, a few long
	always @(posedge clk) begin
		if (stall_long) out_stall <= ($urandom_range(0, 9) < 8);
		else out_stall <= ($urandom_range(0, 3) == 0);
	end
	initial begin
		stall_long = 0;
		forever begin
			repeat ($urandom_range(50, 400)) @(posedge clk);
			stall_long = ($urandom_range(0, 5) == 0);
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// setup and access phase, then the bus idles
	task automatic cfg_write(reg_idx_t idx, logic [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	// one input transfer; valid stays up for back-to-back items
	task automatic send_item(logic m, logic [3:0] cl, logic [3:0] nl, logic [2:0] sb,
			logic [15:0] rw, logic [15:0] rd, logic [15:0] rp);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1; mode <= m; current_load <= cl; next_load <= nl;
		served_backend <= sb; reward_value <= rw; random_draw <= rd; random_pick <= rp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		if (m) feedbacks++; else selects++;
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic rand_item();
		logic [15:0] rd;
		rd = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		send_item(1'($urandom_range(0, 1)), 4'($urandom), 4'($urandom), 3'($urandom),
			16'($urandom), rd, 16'($urandom));
	endtask

	initial begin
		logic [31:0] v;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes at default settings
		send_item(0, 0, 0, 0, 0, 16'h0000, 16'hFFFF);
		send_item(1, 15, 15, 7, 16'h7FFF, 0, 0);
		send_item(1, 15, 15, 7, 16'h7FFF, 0, 0);
		send_item(1, 0, 15, 0, 16'h8000, 0, 0);
		send_item(1, 3, 0, 2, 16'h0100, 0, 0);
		send_item(0, 15, 0, 0, 0, 16'hFFFF, 0);
		send_item(0, 3, 0, 0, 0, 16'hFFFF, 0);
		send_item(0, 0, 0, 0, 0, 16'hFFFF, 0);
		drain();
		// out-of-range counts, saturated rates
		cfg_write(REG_BACKENDS, 0);
		cfg_write(REG_STATES, 0);
		cfg_write(REG_LEARN, 32'h1FFFF);
		cfg_write(REG_DISCOUNT, 32'h10000);
		cfg_write(REG_DECAY, 0);
		cfg_write(REG_MIN_EXP, 0);
		send_item(1, 9, 9, 5, 16'h8000, 0, 0);
		send_item(0, 9, 0, 0, 0, 16'hFFFF, 16'hFFFF);
		send_item(0, 9, 0, 0, 0, 0, 16'hFFFF);
		drain();
		cfg_write(REG_BACKENDS, 15);
		cfg_write(REG_STATES, 31);
		cfg_write(REG_MIN_EXP, 32'h1FFFF);
		cfg_write(REG_DECAY, 32'h10000);
		send_item(1, 15, 15, 7, 16'h7FFF, 0, 0);
		send_item(0, 15, 0, 0, 0, 16'hFFFF, 16'h1234);
		drain();
		// random phases over varied settings
		for (int ph = 0; ph < 12; ph++) begin
			cfg_write(REG_BACKENDS, (ph % 3 == 0) ? 16'($urandom_range(0, 15))
				: $urandom_range(1, 8));
			cfg_write(REG_STATES, (ph % 3 == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16));
			for (int r = 2; r < 6; r++) begin
				v = $urandom_range(0, 3);
				v = (v == 0) ? 32'h0 : (v == 1) ? 32'h10000 : (v == 2) ? $urandom : $urandom_range(0, 65536);
				if (r == REG_DECAY && ph % 2) v = $urandom_range(40000, 65536);
				if (r == REG_MIN_EXP && ph % 2) v = $urandom_range(0, 20000);
				cfg_write(reg_idx_t'(r), v);
			end
			for (int i = 0; i < 105; i++) rand_item();
			drain();
		end
		$display("ran %0d items (%0d selects, %0d feedbacks) over 15 register settings",
			sent, selects, feedbacks);
		if (fail_count == 0) $display("q_learning_backend_selector regression: pass");
		else $display("q_learning_backend_selector regression: fail");
		$finish;
	end

endmodule
